/* sv/ncr_pkg.sv */
// ncr_pkg: shared types, codes and constants of the cubic newton root block
// used by ncr_ctrl, ncr_datapath and newton_cubic_root_top
`default_nettype none

package ncr_pkg;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_VALUE_TOL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_TOL  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ITER_LIM  = 2'd2;

    localparam logic [30:0] VALUE_TOL_RESET = 31'd33;
    localparam logic [30:0] STEP_TOL_RESET  = 31'd33;
    localparam logic [7:0]  ITER_LIM_RESET  = 8'd50;

    localparam logic [1:0] ST_VALUE = 2'd0;
    localparam logic [1:0] ST_STEP  = 2'd1;
    localparam logic [1:0] ST_LIMIT = 2'd2;
    localparam logic [1:0] ST_DZERO = 2'd3;

    localparam int DIV_STEPS = 48;

    typedef struct packed {
        logic       load;
        logic       mul_sq;
        logic       round_sq;
        logic       mul_cu;
        logic       feval;
        logic       commit;
        logic       div_load;
        logic       div_step;
        logic       step_next;
        logic       emit;
        logic       emit_cur;
        logic [1:0] emit_status;
        logic [7:0] emit_iters;
    } ncr_cmd_t;

    typedef struct packed {
        logic f_small;
        logic step_small;
        logic d_zero;
    } ncr_stat_t;

    function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
        begin
            r = 32'sh7FFFFFFF;
        end
        else if (v < -64'sd2147483648)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* sv/ncr_ctrl.sv */
// ncr_ctrl: sequencer of the newton iteration, iteration and divide counters
// depends on ncr_pkg
`default_nettype none

module ncr_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [7:0]        iteration_limit,
    input  wire ncr_pkg::ncr_stat_t stat,
    output logic                   busy,
    output ncr_pkg::ncr_cmd_t      cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SQ   = 4'd1;
    localparam logic [3:0] S_SQR  = 4'd2;
    localparam logic [3:0] S_CU   = 4'd3;
    localparam logic [3:0] S_FV   = 4'd4;
    localparam logic [3:0] S_TEST = 4'd5;
    localparam logic [3:0] S_LOOP = 4'd6;
    localparam logic [3:0] S_DIV  = 4'd7;
    localparam logic [3:0] S_NXT  = 4'd8;
    localparam logic [3:0] S_FIN  = 4'd9;

    localparam int DCW = $clog2(ncr_pkg::DIV_STEPS);

    logic [3:0]     state_reg, state_next;
    logic [7:0]     cnt_reg, cnt_next;
    logic [DCW-1:0] dcnt_reg, dcnt_next;
    logic           first_reg, first_next;
    logic           final_reg, final_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            dcnt_reg  <= '0;
            first_reg <= 1'b0;
            final_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            dcnt_reg  <= dcnt_next;
            first_reg <= first_next;
            final_reg <= final_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        dcnt_next  = dcnt_reg;
        first_next = first_reg;
        final_next = final_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    first_next = 1'b1;
                    final_next = 1'b0;
                    state_next = S_SQ;
                end
            end
            S_SQ:
            begin
                cmd.mul_sq = 1'b1;
                state_next = S_SQR;
            end
            S_SQR:
            begin
                cmd.round_sq = 1'b1;
                state_next   = S_CU;
            end
            S_CU:
            begin
                cmd.mul_cu = 1'b1;
                state_next = S_FV;
            end
            S_FV:
            begin
                cmd.feval  = 1'b1;
                state_next = S_TEST;
            end
            S_TEST:
            begin
                if (stat.f_small)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = ncr_pkg::ST_VALUE;
                    cmd.emit_iters  = first_reg ? cnt_reg : cnt_reg + 8'd1;
                    state_next      = S_IDLE;
                end
                else if (!first_reg && stat.step_small)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = ncr_pkg::ST_STEP;
                    cmd.emit_iters  = cnt_reg + 8'd1;
                    state_next      = S_IDLE;
                end
                else
                begin
                    cmd.commit = 1'b1;
                    if (!first_reg)
                    begin
                        cnt_next = cnt_reg + 8'd1;
                    end
                    first_next = 1'b0;
                    state_next = S_LOOP;
                end
            end
            S_LOOP:
            begin
                if (stat.d_zero)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_cur    = 1'b1;
                    cmd.emit_status = ncr_pkg::ST_DZERO;
                    cmd.emit_iters  = cnt_reg;
                    state_next      = S_IDLE;
                end
                else
                begin
                    cmd.div_load = 1'b1;
                    dcnt_next    = '0;
                    final_next   = (cnt_reg == iteration_limit);
                    state_next   = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                dcnt_next    = dcnt_reg + 1'b1;
                if (dcnt_reg == DCW'(ncr_pkg::DIV_STEPS - 1))
                begin
                    state_next = S_NXT;
                end
            end
            S_NXT:
            begin
                cmd.step_next = 1'b1;
                state_next    = final_reg ? S_FIN : S_SQ;
            end
            S_FIN:
            begin
                cmd.emit        = 1'b1;
                cmd.emit_status = ncr_pkg::ST_LIMIT;
                cmd.emit_iters  = cnt_reg;
                state_next      = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* sv/ncr_datapath.sv */
// ncr_datapath: shared multiplier, cubic and derivative evaluation, serial divider,
// convergence tests and result registers; depends on ncr_pkg
`default_nettype none

module ncr_datapath (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire ncr_pkg::ncr_cmd_t  cmd,
    input  wire logic signed [31:0] start_value,
    input  wire logic [30:0]        value_tolerance,
    input  wire logic [30:0]        step_tolerance,
    output ncr_pkg::ncr_stat_t      stat,
    output logic                    done,
    output logic signed [31:0]      root,
    output logic [1:0]              status,
    output logic [7:0]              iterations_used
);

    localparam int DW = ncr_pkg::DIV_STEPS;

    logic signed [31:0] x_reg, cur_reg, f_reg, f_cur_reg;
    logic [30:0]        sq_reg, sq_cur_reg;
    logic signed [63:0] prod_reg;
    logic [31:0]        rem_reg, dmag_reg;
    logic [DW-1:0]      num_reg;
    logic               qneg_reg;
    logic               done_reg;
    logic signed [31:0] root_reg;
    logic [1:0]         status_reg;
    logic [7:0]         iters_reg;

    logic signed [31:0] mul_a;
    logic signed [63:0] prod_wide;
    logic [63:0]        sq_sum, pmag, csum;
    logic [30:0]        sq_round;
    logic [46:0]        cmag;
    logic signed [48:0] cube;
    logic signed [50:0] fsum;
    logic signed [31:0] f_val;
    logic [31:0]        fmag, fcmag;
    logic signed [32:0] dx;
    logic [32:0]        dxmag;
    logic signed [33:0] dsum;
    logic signed [31:0] d_val;
    logic [31:0]        dvmag;
    logic [32:0]        trial;
    logic               qbit;
    logic signed [31:0] qval;
    logic signed [32:0] nsum;

    assign mul_a     = cmd.mul_cu ? $signed({1'b0, sq_reg}) : x_reg;
    assign prod_wide = mul_a * x_reg;

    assign sq_sum   = prod_reg + 64'sd32768;
    assign sq_round = (|sq_sum[63:47]) ? 31'h7FFFFFFF : sq_sum[46:16];

    assign pmag = prod_reg[63] ? 64'(-prod_reg) : 64'(prod_reg);
    assign csum = pmag + 64'd32768;
    assign cmag = csum[62:16];
    assign cube = prod_reg[63] ? -$signed({2'b00, cmag}) : $signed({2'b00, cmag});
    assign fsum = 51'(cube) - 51'(x_reg) * 51'sd9 + 51'sd196608;
    assign f_val = ncr_pkg::clamp32(64'(fsum));

    assign fmag  = f_reg[31] ? 32'(-f_reg) : 32'(f_reg);
    assign fcmag = f_cur_reg[31] ? 32'(-f_cur_reg) : 32'(f_cur_reg);
    assign dx    = 33'(x_reg) - 33'(cur_reg);
    assign dxmag = dx[32] ? 33'(-dx) : 33'(dx);

    assign dsum  = $signed(34'(sq_cur_reg) * 34'd3) - 34'sd589824;
    assign d_val = ncr_pkg::clamp32(64'(dsum));
    assign dvmag = d_val[31] ? 32'(-d_val) : 32'(d_val);

    assign stat.f_small    = fmag < {1'b0, value_tolerance};
    assign stat.step_small = dxmag < {2'b00, step_tolerance};
    assign stat.d_zero     = (d_val == 32'sd0);

    assign trial = {rem_reg, num_reg[DW-1]};
    assign qbit  = (trial >= {1'b0, dmag_reg});

    always_comb
    begin
        if (qneg_reg)
        begin
            qval = (num_reg > DW'(64'h80000000)) ? 32'sh80000000 : $signed(-num_reg[31:0]);
        end
        else
        begin
            qval = (num_reg > DW'(64'h7FFFFFFF)) ? 32'sh7FFFFFFF : $signed(num_reg[31:0]);
        end
    end

    assign nsum = 33'(cur_reg) - 33'(qval);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg <= start_value;
        end
        if (cmd.step_next)
        begin
            x_reg <= ncr_pkg::clamp32(64'(nsum));
        end
        if (cmd.mul_sq || cmd.mul_cu)
        begin
            prod_reg <= prod_wide;
        end
        if (cmd.round_sq)
        begin
            sq_reg <= sq_round;
        end
        if (cmd.feval)
        begin
            f_reg <= f_val;
        end
        if (cmd.commit)
        begin
            cur_reg    <= x_reg;
            sq_cur_reg <= sq_reg;
            f_cur_reg  <= f_reg;
        end
        if (cmd.div_load)
        begin
            rem_reg  <= '0;
            dmag_reg <= dvmag;
            num_reg  <= {fcmag, 16'd0};
            qneg_reg <= f_cur_reg[31] ^ d_val[31];
        end
        if (cmd.div_step)
        begin
            rem_reg <= qbit ? 32'(trial - {1'b0, dmag_reg}) : trial[31:0];
            num_reg <= {num_reg[DW-2:0], qbit};
        end
        if (cmd.emit)
        begin
            root_reg   <= cmd.emit_cur ? cur_reg : x_reg;
            status_reg <= cmd.emit_status;
            iters_reg  <= cmd.emit_iters;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.emit;
        end
    end

    assign done            = done_reg;
    assign root            = root_reg;
    assign status          = status_reg;
    assign iterations_used = iters_reg;

endmodule

`default_nettype wire

/* sv/newton_cubic_root_top.sv */
// newton_cubic_root_top: newton root finder for x^3 - 9x + 3 in signed q16.16
// depends on ncr_pkg, ncr_ctrl, ncr_datapath
//
// usage
//   a request is taken at a rising edge with start high and busy low; start_value
//   is the initial guess. busy stays high until the result is produced.
//   the result (root, status, iterations_used) is shown for exactly one cycle
//   with done high; the receiver cannot stall, so nothing waits on it.
//   configuration: cfg_valid with cfg_index and cfg_data, cfg_ready always high;
//   index 0 value tolerance, 1 step tolerance, 2 iteration limit, others ignored.
//   write registers only while busy is low.
// sequence
//   a function evaluation squares x, rounds the square, multiplies it by x and forms f
//   (shared 32x32 multiplier, used twice); each newton iteration runs a radix-2 divider.
//   on a zero derivative the last committed guess is reported; on hitting the limit
//   a final step is taken and its result is reported with the limit status.
//   one request at a time.
// reset
//   asynchronous, active low; clears the sequencer and done and loads the
//   tolerances (33) and the iteration limit (50).
`default_nettype none

module newton_cubic_root_top (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [31:0] start_value,
    output logic                    done,
    output logic signed [31:0]      root,
    output logic [1:0]              status,
    output logic [7:0]              iterations_used,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [ncr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]        cfg_data
);

    logic [30:0] vtol_reg, stol_reg;
    logic [7:0]  lim_reg;
    ncr_pkg::ncr_cmd_t  cmd;
    ncr_pkg::ncr_stat_t stat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vtol_reg <= ncr_pkg::VALUE_TOL_RESET;
            stol_reg <= ncr_pkg::STEP_TOL_RESET;
            lim_reg  <= ncr_pkg::ITER_LIM_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                ncr_pkg::CFG_VALUE_TOL: vtol_reg <= cfg_data[30:0];
                ncr_pkg::CFG_STEP_TOL:  stol_reg <= cfg_data[30:0];
                ncr_pkg::CFG_ITER_LIM:  lim_reg  <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    ncr_ctrl u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .iteration_limit (lim_reg),
        .stat            (stat),
        .busy            (busy),
        .cmd             (cmd)
    );

    ncr_datapath u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .start_value     (start_value),
        .value_tolerance (vtol_reg),
        .step_tolerance  (stol_reg),
        .stat            (stat),
        .done            (done),
        .root            (root),
        .status          (status),
        .iterations_used (iterations_used)
    );

`ifndef ASSERT_OFF
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result shown while still busy");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("accepted request did not start a run");
    a_one_emit: assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("two results in a row");
`endif

endmodule

`default_nettype wire
